FILE: sv/dpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_pkg
// shared types and codes for the dual priority queue
// ----------------------------------------------------------------------------
package dpq_pkg;

  localparam int unsigned ItemW  = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned CountW = 5;
  localparam int unsigned OpW    = 3;
  localparam int unsigned StatW  = 2;

  typedef enum logic [OpW-1:0] {
    OP_ENQ     = 3'd0,
    OP_DEQ_A   = 3'd1,
    OP_DEQ_B   = 3'd2,
    OP_DEQ_OLD = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_SHIFT = 2'd2,
    S_DONE  = 2'd3
  } state_t;

  typedef struct packed {
    logic [PrioW-1:0] prio_b;
    logic [PrioW-1:0] prio_a;
    logic [ItemW-1:0] item;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic sample;
    logic use_b;
  } scan_ctrl_t;

endpackage

FILE: sv/dpq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_mem
// entry table, one write port and one registered read port
// ----------------------------------------------------------------------------
module dpq_mem #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  dpq_pkg::entry_t            wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output dpq_pkg::entry_t            rdata
);

  dpq_pkg::entry_t mem [DEPTH];
  dpq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/dpq_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_scan
// running maximum over entries read one per cycle while ctrl.sample is set, earliest wins on a tie
// ----------------------------------------------------------------------------
module dpq_scan #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dpq_pkg::scan_ctrl_t             ctrl,
  input  logic [$clog2(DEPTH)-1:0]        sample_idx,
  input  dpq_pkg::entry_t                 sample_data,
  output logic [$clog2(DEPTH)-1:0]        best_idx,
  output logic [dpq_pkg::ItemW-1:0]       best_item
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                      first_r;
  logic [dpq_pkg::PrioW-1:0] best_key_r;
  logic [AW-1:0]             best_idx_r;
  logic [dpq_pkg::ItemW-1:0] best_item_r;
  logic [dpq_pkg::PrioW-1:0] key;
  logic                      take;

  assign key  = ctrl.use_b ? sample_data.prio_b : sample_data.prio_a;
  assign take = ctrl.sample && (first_r || ($signed(key) > $signed(best_key_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (ctrl.clear) begin
      first_r <= 1'b1;
    end else if (ctrl.sample) begin
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_key_r  <= key;
      best_idx_r  <= sample_idx;
      best_item_r <= sample_data.item;
    end
  end

  assign best_idx  = best_idx_r;
  assign best_item = best_item_r;

endmodule

FILE: sv/dual_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_priority_queue
// arrival-ordered table with removal by highest a, highest b or oldest
// ----------------------------------------------------------------------------
//  channel | ports       | tdata (low bit up)                  | tuser
//  --------+-------------+-------------------------------------+--------
//  in      | in_t*       | item_value, priority_a, priority_b  | opcode
//  out     | out_t*      | item_out, status, entry_count, pad  | -
//
//  one request at a time; enqueue, clear and rejected requests go from idle
//  straight to done; dequeue by a or b scans every entry held through the
//  single memory read port, then compacts the entries behind the removed
//  entry; dequeue oldest scans only the oldest entry, then compacts the rest
//  synchronous active-low reset empties the table at once
//  a held result stalls completion of the next request, not its transfer in
// ----------------------------------------------------------------------------
module dual_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // item_value[31:0], priority_a[47:32], priority_b[63:48]
  input  logic [2:0]  in_tuser,   // opcode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // item_out[31:0], status[33:32], entry_count[38:34]
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dpq_pkg::state_t   state_r, state_nxt;
  dpq_pkg::op_t      op_r, op_nxt;
  dpq_pkg::status_t  res_status_r, res_status_nxt;
  logic [dpq_pkg::ItemW-1:0] res_item_r, res_item_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     end_r, end_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [AW-1:0]     pend_idx_r, pend_idx_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [39:0]       out_tdata_r, out_tdata_nxt;

  dpq_pkg::op_t        in_op;
  logic                accept;
  logic                is_empty;
  logic                is_full;
  logic                scan_issue;
  logic                shift_issue;
  logic                out_free;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  dpq_pkg::entry_t     mem_wdata;
  dpq_pkg::entry_t     mem_rdata;
  dpq_pkg::entry_t     in_entry;
  dpq_pkg::scan_ctrl_t scan_ctrl;
  logic [AW-1:0]       best_idx;
  logic [dpq_pkg::ItemW-1:0] best_item;

  assign in_op       = dpq_pkg::op_t'(in_tuser);
  assign accept      = in_tvalid && in_tready;
  assign is_empty    = (occ_r == '0);
  assign is_full     = (occ_r == CW'(DEPTH));
  assign scan_issue  = (ptr_r < end_r);
  assign shift_issue = (ptr_r < occ_r);
  assign out_free    = !out_tvalid_r || out_tready;

  assign in_entry.item   = in_tdata[31:0];
  assign in_entry.prio_a = in_tdata[47:32];
  assign in_entry.prio_b = in_tdata[63:48];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dpq_pkg::S_IDLE: begin
        if (accept) begin
          if ((in_op == dpq_pkg::OP_DEQ_A || in_op == dpq_pkg::OP_DEQ_B ||
               in_op == dpq_pkg::OP_DEQ_OLD) && !is_empty) begin
            state_nxt = dpq_pkg::S_SCAN;
          end else begin
            state_nxt = dpq_pkg::S_DONE;
          end
        end
      end
      dpq_pkg::S_SCAN: begin
        if (!scan_issue && !pend_vld_r) begin
          state_nxt = dpq_pkg::S_SHIFT;
        end
      end
      dpq_pkg::S_SHIFT: begin
        if (!shift_issue && !pend_vld_r) begin
          state_nxt = dpq_pkg::S_DONE;
        end
      end
      dpq_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = dpq_pkg::S_IDLE;
        end
      end
      default: state_nxt = dpq_pkg::S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_tready        = (state_r == dpq_pkg::S_IDLE);
    mem_we           = 1'b0;
    mem_waddr        = occ_r[AW-1:0];
    mem_wdata        = in_entry;
    scan_ctrl.clear  = accept;
    scan_ctrl.sample = (state_r == dpq_pkg::S_SCAN) && pend_vld_r;
    scan_ctrl.use_b  = (op_r == dpq_pkg::OP_DEQ_B);
    case (state_r)
      dpq_pkg::S_IDLE: begin
        mem_we = accept && (in_op == dpq_pkg::OP_ENQ) && !is_full;
      end
      dpq_pkg::S_SHIFT: begin
        mem_we    = pend_vld_r;
        mem_waddr = pend_idx_r - AW'(1);
        mem_wdata = mem_rdata;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    op_nxt         = op_r;
    res_status_nxt = res_status_r;
    res_item_nxt   = res_item_r;
    occ_nxt        = occ_r;
    ptr_nxt        = ptr_r;
    end_nxt        = end_r;
    pend_vld_nxt   = 1'b0;
    pend_idx_nxt   = ptr_r[AW-1:0];
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    case (state_r)
      dpq_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt         = in_op;
          res_item_nxt   = '0;
          res_status_nxt = dpq_pkg::ST_OK;
          ptr_nxt        = '0;
          end_nxt        = (in_op == dpq_pkg::OP_DEQ_OLD) ? CW'(1) : occ_r;
          case (in_op)
            dpq_pkg::OP_ENQ: begin
              if (is_full) begin
                res_status_nxt = dpq_pkg::ST_FULL;
              end else begin
                occ_nxt = occ_r + CW'(1);
              end
            end
            dpq_pkg::OP_DEQ_A, dpq_pkg::OP_DEQ_B, dpq_pkg::OP_DEQ_OLD: begin
              if (is_empty) begin
                res_status_nxt = dpq_pkg::ST_EMPTY;
              end
            end
            dpq_pkg::OP_CLEAR: begin
              occ_nxt = '0;
            end
            default: begin
              occ_nxt = occ_r;
            end
          endcase
        end
      end
      dpq_pkg::S_SCAN: begin
        if (scan_issue) begin
          pend_vld_nxt = 1'b1;
          ptr_nxt      = ptr_r + CW'(1);
        end else if (!pend_vld_r) begin
          ptr_nxt = CW'(best_idx) + CW'(1);
        end
      end
      dpq_pkg::S_SHIFT: begin
        if (shift_issue) begin
          pend_vld_nxt = 1'b1;
          ptr_nxt      = ptr_r + CW'(1);
        end else if (!pend_vld_r) begin
          occ_nxt      = occ_r - CW'(1);
          res_item_nxt = best_item;
        end
      end
      dpq_pkg::S_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0, dpq_pkg::CountW'(occ_r), res_status_r, res_item_r};
        end
      end
      default: begin
        pend_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dpq_pkg::S_IDLE;
      occ_r        <= '0;
      pend_vld_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    res_status_r <= res_status_nxt;
    res_item_r   <= res_item_nxt;
    ptr_r        <= ptr_nxt;
    end_r        <= end_nxt;
    pend_idx_r   <= pend_idx_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  dpq_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (ptr_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  dpq_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (scan_ctrl),
    .sample_idx  (pend_idx_r),
    .sample_data (mem_rdata),
    .best_idx    (best_idx),
    .best_item   (best_item)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
